// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet while rst_n is low
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_AT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/dbdu_pkg.sv -----
// Package for the decimal digit unit: request and response types, op codes, state type, constants
`default_nettype none

package dbdu_pkg;

  localparam int FACTOR_BITS_DEF = 16;
  localparam int DEC_BASE        = 10;
  localparam int DIGIT_MAX       = 9;
  localparam int FACTOR_RESET    = 1;
  localparam int CFG_W           = 16;
  localparam int RUN_OUT_W       = 16;

  localparam logic [1:0] OP_DIV = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic       start_of_number;
    logic [3:0] digit_a;
    logic [3:0] digit_b;
  } dbdu_req_t;

  typedef struct packed {
    logic [3:0]           result_digit;
    logic [RUN_OUT_W-1:0] running_value;
    logic                 borrow_out;
  } dbdu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ITER = 3'b010,
    S_DONE = 3'b100
  } dbdu_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/decimal_bignum_digit_unit.sv -----
// Decimal digit unit: divide, multiply and subtract steps; divide runs a restoring divider
//
//   channel  direction  handshake          payload
//   in_      request    in_valid/in_stall  dbdu_req_t in_req
//   out_     response   out_valid/out_stall dbdu_rsp_t out_rsp
//   cfg_     write      cfg_wr_en          cfg_wr_data (factor)
//
// Divide: runs the one-bit-per-cycle restoring divider by the factor.
// Multiply: carry split by ten through a reciprocal multiply.
// Subtract, divide by zero and op three skip the iteration state.
// One request at a time; a finished response waits in the output register, a new
//   request is taken while it waits; a response that finds it full holds the unit.
// rst_n synchronous: factor to one, remainder, borrow and control cleared.
`default_nettype none

module decimal_bignum_digit_unit #(
  parameter int FACTOR_BITS = dbdu_pkg::FACTOR_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire dbdu_pkg::dbdu_req_t      in_req,
  output logic                          out_valid,
  input  wire                           out_stall,
  output dbdu_pkg::dbdu_rsp_t           out_rsp,
  input  wire                           cfg_wr_en,
  input  wire [dbdu_pkg::CFG_W-1:0]     cfg_wr_data
);
  import dbdu_pkg::*;

  `include "assert_macros.svh"

  localparam int W     = FACTOR_BITS + 4;
  localparam int CNT_W = $clog2(W);
  localparam int PW    = 2 * W;
  localparam logic [W-1:0] MUL_RECIP =
    W'(((64'd1 << (W + 3)) + 64'(DEC_BASE) - 64'd1) / 64'(DEC_BASE));

  dbdu_state_t             state_r, state_nxt;
  logic [FACTOR_BITS-1:0]  factor_r, factor_nxt;
  logic [FACTOR_BITS-1:0]  rem_r, rem_nxt;
  logic                    borrow_r, borrow_nxt;
  logic                    out_valid_r, out_valid_nxt;
  dbdu_rsp_t               out_r, out_nxt;
  logic [1:0]              op_r, op_nxt;
  logic                    fzero_r, fzero_nxt;
  logic [W-1:0]            n_r, n_nxt;
  logic [FACTOR_BITS-1:0]  p_r, p_nxt;
  logic [FACTOR_BITS-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic [FACTOR_BITS-1:0]  rem_eff;
  logic                    brw_eff;
  logic [W-1:0]            div_u;
  logic [W-1:0]            mul_p;
  logic signed [6:0]       sub_t;
  logic signed [6:0]       sub_c;
  logic                    sub_neg;
  logic [3:0]              sub_dig;
  logic [FACTOR_BITS:0]    trial;
  logic                    trial_ge;
  logic [FACTOR_BITS:0]    trial_sub;
  logic [PW-1:0]           mul_prod;
  logic [W-4:0]            mul_c;
  logic [W-1:0]            mul_rest;
  logic [3:0]              mul_d;
  dbdu_rsp_t               fin;
  logic [FACTOR_BITS-1:0]  fin_rem;
  logic                    out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // operand set-up for a new request
  always_comb begin
    rem_eff = in_req.start_of_number ? '0 : rem_r;
    brw_eff = in_req.start_of_number ? 1'b0 : borrow_r;
    div_u   = (W'(rem_eff) << 3) + (W'(rem_eff) << 1) + W'(in_req.digit_a);
    mul_p   = W'(factor_r) * W'(in_req.digit_a) + W'(rem_eff);
    sub_t   = $signed({3'b000, in_req.digit_a}) - $signed({3'b000, in_req.digit_b})
              - $signed({6'b000000, brw_eff});
    sub_neg = sub_t[6];
    sub_c   = sub_neg ? (sub_t + 7'sd10) : sub_t;
    if (sub_c[6]) begin
      sub_dig = 4'd0;
    end else if (sub_c > 7'(DIGIT_MAX)) begin
      sub_dig = 4'(DIGIT_MAX);
    end else begin
      sub_dig = sub_c[3:0];
    end
  end

  // one restoring step
  always_comb begin
    trial     = {p_r, n_r[W-1]};
    trial_ge  = (trial >= {1'b0, div_r});
    trial_sub = trial - {1'b0, div_r};
  end

  // product split into carry and digit by reciprocal multiply
  always_comb begin
    mul_prod = PW'(n_r) * PW'(MUL_RECIP);
    mul_c    = mul_prod[PW-1:W+3];
    mul_rest = n_r - (W'(mul_c) << 3) - (W'(mul_c) << 1);
    mul_d    = mul_rest[3:0];
  end

  // response from the finished working registers
  always_comb begin
    fin     = '0;
    fin_rem = rem_r;
    case (op_r)
      OP_DIV: begin
        if (fzero_r) begin
          fin.result_digit = 4'(DIGIT_MAX);
          fin_rem          = '0;
        end else begin
          fin.result_digit = (n_r > W'(DIGIT_MAX)) ? 4'(DIGIT_MAX) : n_r[3:0];
          fin_rem          = p_r;
        end
        fin.running_value = RUN_OUT_W'(fin_rem);
      end
      OP_MUL: begin
        fin.result_digit  = p_r[3:0];
        fin_rem           = (|n_r[W-1:FACTOR_BITS]) ? '1 : n_r[FACTOR_BITS-1:0];
        fin.running_value = RUN_OUT_W'(fin_rem);
      end
      OP_SUB: begin
        fin.result_digit = p_r[3:0];
        fin.borrow_out   = borrow_r;
      end
      default: begin
        fin = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    factor_nxt    = cfg_wr_en ? FACTOR_BITS'(cfg_wr_data) : factor_r;
    rem_nxt       = rem_r;
    borrow_nxt    = borrow_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    op_nxt        = op_r;
    fzero_nxt     = fzero_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_req.req_type;
          fzero_nxt = (factor_r == '0);
          cnt_nxt   = CNT_W'(W - 1);
          p_nxt     = '0;
          if (in_req.req_type != OP_NOP && in_req.start_of_number) begin
            rem_nxt    = '0;
            borrow_nxt = 1'b0;
          end
          case (in_req.req_type)
            OP_DIV: begin
              n_nxt     = div_u;
              div_nxt   = factor_r;
              state_nxt = (factor_r == '0) ? S_DONE : S_ITER;
            end
            OP_MUL: begin
              n_nxt     = mul_p;
              div_nxt   = FACTOR_BITS'(DEC_BASE);
              cnt_nxt   = '0;
              state_nxt = S_ITER;
            end
            OP_SUB: begin
              p_nxt      = FACTOR_BITS'(sub_dig);
              borrow_nxt = sub_neg;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_ITER: begin
        if (op_r == OP_MUL) begin
          p_nxt     = FACTOR_BITS'(mul_d);
          n_nxt     = W'(mul_c);
          state_nxt = S_DONE;
        end else begin
          p_nxt   = trial_ge ? trial_sub[FACTOR_BITS-1:0] : trial[FACTOR_BITS-1:0];
          n_nxt   = {n_r[W-2:0], trial_ge};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = fin;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == OP_DIV || op_r == OP_MUL) begin
            rem_nxt = fin_rem;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      factor_r    <= FACTOR_BITS'(FACTOR_RESET);
      rem_r       <= '0;
      borrow_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      factor_r    <= factor_nxt;
      rem_r       <= rem_nxt;
      borrow_r    <= borrow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    op_r    <= op_nxt;
    fzero_r <= fzero_nxt;
    n_r     <= n_nxt;
    p_r     <= p_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
  end

  `ASSERT_AT(a_accept_busy, (in_valid && !in_stall) |=> (state_r != S_IDLE), "request taken but unit idle")
  `ASSERT_NEVER(a_rem_below_div, (state_r == S_ITER) && (p_r >= div_r), "partial remainder not below divisor")
  `ASSERT_AT(a_iter_count, (state_r == S_ITER && cnt_r != '0) |=> (state_r == S_ITER && cnt_r == $past(cnt_r) - 1'b1), "divider count slipped")
  `ASSERT_AT(a_load_from_done, (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_DONE), "response loaded outside done")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the decimal digit unit: divide, multiply and subtract requests
`timescale 1ns / 100ps

module testbench;
  import dbdu_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 112;

  typedef struct {
    bit          set_cfg;
    logic [15:0] cfg_val;
    dbdu_req_t   req;
    bit          chk;
    dbdu_rsp_t   rsp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  dbdu_req_t   in_req;
  logic        out_valid;
  logic        out_stall;
  dbdu_rsp_t   out_rsp;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // model state
  logic [15:0] factor_q;
  logic [15:0] run_q;
  bit          borrow_q;

  dbdu_rsp_t   expected_digits[$];
  dir_row_t    dir_rows[$];
  bit          cur_chk;
  dbdu_rsp_t   cur_rsp;
  dbdu_rsp_t   pred_rsp;
  dbdu_rsp_t   exp_rsp;
  int          err_cnt = 0;
  int          idle_cnt = 0;
  int          gap_pct;
  int          stall_pct;
  int          hold_len;
  int          sent;

  decimal_bignum_digit_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp(out_rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic dbdu_rsp_t digit_step(input dbdu_req_t r);
    dbdu_rsp_t   rsp;
    logic [31:0] u;
    logic [31:0] q;
    logic [31:0] p;
    logic [31:0] c;
    int          t;
    bit          neg;
    rsp = '0;
    if (r.req_type == OP_NOP) begin
      return rsp;
    end
    if (r.start_of_number) begin
      run_q = '0;
      borrow_q = 1'b0;
    end
    if (r.req_type == OP_DIV) begin
      u = 32'(run_q) * DEC_BASE + 32'(r.digit_a);
      if (factor_q == 0) begin
        q = DIGIT_MAX;
        run_q = '0;
      end else begin
        q = u / factor_q;
        run_q = 16'(u % factor_q);
        if (q > DIGIT_MAX) begin
          q = DIGIT_MAX;
        end
      end
      rsp.result_digit = q[3:0];
      rsp.running_value = run_q;
    end else if (r.req_type == OP_MUL) begin
      p = 32'(factor_q) * 32'(r.digit_a) + 32'(run_q);
      c = p / DEC_BASE;
      rsp.result_digit = 4'(p % DEC_BASE);
      if (c > 32'hFFFF) begin
        c = 32'hFFFF;
      end
      run_q = c[15:0];
      rsp.running_value = run_q;
    end else begin
      t = int'(r.digit_a) - int'(r.digit_b) - int'(borrow_q);
      neg = (t < 0);
      if (neg) begin
        t += DEC_BASE;
      end
      if (t < 0) begin
        t = 0;
      end
      if (t > DIGIT_MAX) begin
        t = DIGIT_MAX;
      end
      borrow_q = neg;
      rsp.result_digit = 4'(t);
      rsp.borrow_out = neg;
    end
    return rsp;
  endfunction

  function automatic logic [3:0] pick_digit();
    if ($urandom_range(19) == 0) begin
      return 4'($urandom_range(15, 10));
    end
    return 4'($urandom_range(9));
  endfunction

  task automatic add_row(input bit sc, input logic [15:0] cv, input logic [1:0] op,
                         input bit sn, input logic [3:0] a, input logic [3:0] b,
                         input bit chk, input logic [3:0] d, input logic [15:0] rv,
                         input bit bo);
    dir_row_t row;
    row.set_cfg = sc;
    row.cfg_val = cv;
    row.req.req_type = op;
    row.req.start_of_number = sn;
    row.req.digit_a = a;
    row.req.digit_b = b;
    row.chk = chk;
    row.rsp.result_digit = d;
    row.rsp.running_value = rv;
    row.rsp.borrow_out = bo;
    dir_rows.push_back(row);
  endtask

  task automatic send_req(input dbdu_req_t r, input bit chk, input dbdu_rsp_t rsp);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_req = r;
    cur_chk = chk;
    cur_rsp = rsp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_digits.size() != 0) @(negedge clk);
  endtask

  task automatic write_factor(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    factor_q = v;
  endtask

  // one number (or a stray request) with random content
  task automatic send_number();
    dbdu_req_t  r;
    int         len;
    logic [1:0] op;
    if ($urandom_range(99) < 15) begin
      r.req_type = 2'($urandom_range(3));
      r.start_of_number = 1'($urandom_range(1));
      r.digit_a = 4'($urandom_range(15));
      r.digit_b = 4'($urandom_range(15));
      send_req(r, 1'b0, '0);
      sent++;
      return;
    end
    op = 2'($urandom_range(2));
    len = $urandom_range(10, 1);
    for (int k = 0; k < len; k++) begin
      r.req_type = ($urandom_range(24) == 0) ? OP_NOP : op;
      r.start_of_number = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
      r.digit_a = pick_digit();
      r.digit_b = pick_digit();
      send_req(r, 1'b0, '0);
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred_rsp = digit_step(in_req);
        expected_digits.push_back(cur_chk ? cur_rsp : pred_rsp);
      end
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected response: digit %0d run %0d borrow %0d",
                     out_rsp.result_digit, out_rsp.running_value, out_rsp.borrow_out);
          end
        end else begin
          exp_rsp = expected_digits.pop_front();
          if (out_rsp !== exp_rsp) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: exp digit %0d run %0d borrow %0d, got digit %0d run %0d borrow %0d",
                       exp_rsp.result_digit, exp_rsp.running_value, exp_rsp.borrow_out,
                       out_rsp.result_digit, out_rsp.running_value, out_rsp.borrow_out);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
    end
  end

  initial begin
    while (idle_cnt < IDLE_LIMIT) @(negedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_stall = 1'b1;
        hold_len--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cur_chk = 1'b0;
    cur_rsp = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    factor_q = 16'(FACTOR_RESET);
    run_q = '0;
    borrow_q = 1'b0;

    // factor one after reset
    add_row(0, 0,     OP_DIV, 1, 9,  0,  1, 9, 0,     0);
    add_row(0, 0,     OP_DIV, 0, 0,  0,  1, 0, 0,     0);
    add_row(0, 0,     OP_DIV, 1, 15, 0,  1, 9, 0,     0);
    add_row(0, 0,     OP_MUL, 1, 9,  0,  1, 9, 0,     0);
    add_row(0, 0,     OP_MUL, 1, 15, 0,  1, 5, 1,     0);
    add_row(0, 0,     OP_MUL, 0, 7,  3,  0, 0, 0,     0);
    add_row(0, 0,     OP_SUB, 1, 0,  9,  1, 1, 0,     1);
    add_row(0, 0,     OP_SUB, 0, 0,  0,  1, 9, 0,     1);
    add_row(0, 0,     OP_SUB, 1, 15, 0,  1, 9, 0,     0);
    add_row(0, 0,     OP_SUB, 1, 0,  15, 1, 0, 0,     1);
    // no-op leaves the borrow pending
    add_row(0, 0,     OP_NOP, 1, 15, 15, 1, 0, 0,     0);
    add_row(0, 0,     OP_SUB, 0, 9,  9,  1, 9, 0,     1);
    add_row(0, 0,     OP_SUB, 0, 9,  0,  0, 0, 0,     0);
    // divisor zero
    add_row(1, 0,     OP_DIV, 1, 5,  0,  1, 9, 0,     0);
    add_row(0, 0,     OP_MUL, 1, 9,  0,  1, 0, 0,     0);
    add_row(0, 0,     OP_DIV, 0, 0,  0,  0, 0, 0,     0);
    // largest factor: carry saturation, quotient saturation; then factor seven
    add_row(1, 65535, OP_MUL, 1, 15, 0,  1, 5, 65535, 0);
    add_row(0, 0,     OP_MUL, 0, 15, 0,  1, 0, 65535, 0);
    add_row(0, 0,     OP_DIV, 0, 9,  0,  1, 9, 9,     0);
    add_row(0, 0,     OP_DIV, 1, 9,  0,  1, 0, 9,     0);
    add_row(1, 7,     OP_DIV, 1, 1,  0,  1, 0, 1,     0);
    add_row(0, 0,     OP_DIV, 0, 4,  0,  1, 2, 0,     0);
    add_row(0, 0,     OP_DIV, 0, 5,  0,  0, 0, 0,     0);
    add_row(0, 0,     OP_MUL, 1, 8,  0,  1, 6, 5,     0);
    add_row(0, 0,     OP_DIV, 0, 3,  0,  1, 7, 4,     0);
    add_row(0, 0,     OP_MUL, 0, 9,  0,  0, 0, 0,     0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        wait_drain();
        write_factor(dir_rows[i].cfg_val);
      end
      send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      case (ph)
        0: write_factor(16'd7);
        1: write_factor(16'hFFFF);
        2: write_factor(16'($urandom_range(99, 2)));
        3: write_factor(16'd0);
        4: write_factor(16'd10);
        5: write_factor(16'd1);
        6: write_factor(16'($urandom_range(65534, 100)));
        default: write_factor(16'd3);
      endcase
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 50;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 50;
        end
        default: begin
          gap_pct = 8;
          stall_pct = 8;
        end
      endcase
      // receiver holds off while requests keep coming
      if (ph == 4) begin
        hold_len = LONG_HOLD;
      end
      sent = 0;
      while (sent < PHASE_REQS) begin
        send_number();
      end
    end

    wait_drain();
    repeat (40) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dbdu_pkg.sv
hw/rtl/decimal_bignum_digit_unit.sv
sim/testbench.sv
